// ----- rtl/flp_pkg.sv -----
// Shared types and constants for the lead/header/length frame parser.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package flp_pkg;

    // Number of lead bytes that open a frame (legal range 1..7)
    localparam int unsigned LEAD_COUNT = 4;
    localparam int unsigned LEAD_CNT_W = 3;
    localparam int unsigned CFG_IDX_W  = 2;

    // Reset values of the configuration registers
    localparam logic [7:0] LEAD_BYTE_RST   = 8'hFE;
    localparam logic [7:0] HEADER_BYTE_RST = 8'h00;
    localparam logic [7:0] END_BYTE_RST    = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd2;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_HEADER = 3'd1,
        PH_CTRL   = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4,
        PH_END    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_CONTROL  = 3'd1,
        EV_LENGTH   = 3'd2,
        EV_PAYLOAD  = 3'd3,
        EV_COMPLETE = 3'd4,
        EV_ABORTED  = 3'd5
    } event_t;

    // One result beat
    typedef struct packed {
        event_t     event_res;
        logic [7:0] byte_value;
        logic [7:0] payload_index;
        logic [7:0] frame_control;
        logic [7:0] frame_length;
    } result_t;

    // Register write, as seen by the deframer
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } cfg_wr_t;

endpackage

// ----- rtl/flp_if.sv -----
// Channel interfaces of the frame parser: received bytes, result events, register writes.
// Depends on flp_pkg.
`timescale 1ns / 1ps

interface flp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface flp_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] byte_value;
    logic [7:0] payload_index;
    logic [7:0] frame_control;
    logic [7:0] frame_length;

    modport source (output valid, output event_res, output byte_value, output payload_index,
                    output frame_control, output frame_length, input ready);
    modport sink   (input valid, input event_res, input byte_value, input payload_index,
                    input frame_control, input frame_length, output ready);
endinterface

interface flp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [flp_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/flp_deframer.sv -----
// Frame hunt state, configuration registers and per-byte result decode.
// Depends on flp_pkg.
`timescale 1ns / 1ps

module flp_deframer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat,
    input  logic [7:0]       rx_byte,
    input  flp_pkg::cfg_wr_t cfg_wr,
    output flp_pkg::result_t result
);

    logic [7:0] lead_byte_reg;
    logic [7:0] header_byte_reg;
    logic [7:0] end_byte_reg;

    flp_pkg::phase_t                 phase_reg, phase_next;
    logic [flp_pkg::LEAD_CNT_W-1:0]  lead_seen_reg, lead_seen_next;
    logic [7:0]                      payload_left_reg, payload_left_next;
    logic [7:0]                      payload_pos_reg, payload_pos_next;
    logic [7:0]                      held_control_reg, held_control_next;
    logic [7:0]                      held_length_reg, held_length_next;

    logic [flp_pkg::LEAD_CNT_W-1:0]  lead_inc;
    logic [7:0]                      left_dec;

    // Configuration registers; new values take effect from the next byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_byte_reg   <= flp_pkg::LEAD_BYTE_RST;
            header_byte_reg <= flp_pkg::HEADER_BYTE_RST;
            end_byte_reg    <= flp_pkg::END_BYTE_RST;
        end
        else if (cfg_wr.valid)
        begin
            if (cfg_wr.index == flp_pkg::CFG_LEAD)
                lead_byte_reg <= cfg_wr.data;
            if (cfg_wr.index == flp_pkg::CFG_HEADER)
                header_byte_reg <= cfg_wr.data;
            if (cfg_wr.index == flp_pkg::CFG_END)
                end_byte_reg <= cfg_wr.data;
        end
    end

    // Hunt state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= flp_pkg::PH_LEAD;
            lead_seen_reg    <= '0;
            payload_left_reg <= '0;
            payload_pos_reg  <= '0;
            held_control_reg <= '0;
            held_length_reg  <= '0;
        end
        else if (beat)
        begin
            phase_reg        <= phase_next;
            lead_seen_reg    <= lead_seen_next;
            payload_left_reg <= payload_left_next;
            payload_pos_reg  <= payload_pos_next;
            held_control_reg <= held_control_next;
            held_length_reg  <= held_length_next;
        end
    end

    assign lead_inc = lead_seen_reg + 1'b1;
    assign left_dec = payload_left_reg - 8'd1;

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        lead_seen_next    = lead_seen_reg;
        payload_left_next = payload_left_reg;
        payload_pos_next  = payload_pos_reg;
        held_control_next = held_control_reg;
        held_length_next  = held_length_reg;

        result.event_res     = flp_pkg::EV_NONE;
        result.byte_value    = rx_byte;
        result.payload_index = '0;
        result.frame_control = '0;
        result.frame_length  = '0;

        unique case (phase_reg)
            flp_pkg::PH_LEAD:
            begin
                if (rx_byte != lead_byte_reg)
                begin
                    lead_seen_next    = '0;
                    payload_left_next = '0;
                    payload_pos_next  = '0;
                    held_control_next = '0;
                    held_length_next  = '0;
                end
                else
                begin
                    lead_seen_next = lead_inc;
                    if (lead_inc >= flp_pkg::LEAD_CNT_W'(flp_pkg::LEAD_COUNT))
                        phase_next = flp_pkg::PH_HEADER;
                end
            end
            flp_pkg::PH_HEADER:
            begin
                if (rx_byte != header_byte_reg)
                begin
                    phase_next        = flp_pkg::PH_LEAD;
                    lead_seen_next    = '0;
                    payload_left_next = '0;
                    payload_pos_next  = '0;
                    held_control_next = '0;
                    held_length_next  = '0;
                end
                else
                    phase_next = flp_pkg::PH_CTRL;
            end
            flp_pkg::PH_CTRL:
            begin
                held_control_next = rx_byte;
                result.event_res  = flp_pkg::EV_CONTROL;
                phase_next        = flp_pkg::PH_LEN;
            end
            flp_pkg::PH_LEN:
            begin
                held_length_next  = rx_byte;
                payload_left_next = rx_byte;
                payload_pos_next  = '0;
                result.event_res  = flp_pkg::EV_LENGTH;
                phase_next        = (rx_byte == 8'd0) ? flp_pkg::PH_END : flp_pkg::PH_DATA;
            end
            flp_pkg::PH_DATA:
            begin
                result.event_res     = flp_pkg::EV_PAYLOAD;
                result.payload_index = payload_pos_reg;
                payload_pos_next     = payload_pos_reg + 8'd1;
                payload_left_next    = left_dec;
                if (left_dec == 8'd0)
                    phase_next = flp_pkg::PH_END;
            end
            flp_pkg::PH_END:
            begin
                result.event_res     = (rx_byte == end_byte_reg) ? flp_pkg::EV_COMPLETE
                                                                 : flp_pkg::EV_ABORTED;
                result.frame_control = held_control_reg;
                result.frame_length  = held_length_reg;
                phase_next           = flp_pkg::PH_LEAD;
                lead_seen_next       = '0;
                payload_left_next    = '0;
                payload_pos_next     = '0;
                held_control_next    = '0;
                held_length_next     = '0;
            end
            default:
            begin
                // unused phase code: back to the hunt
                phase_next        = flp_pkg::PH_LEAD;
                lead_seen_next    = '0;
                payload_left_next = '0;
                payload_pos_next  = '0;
                held_control_next = '0;
                held_length_next  = '0;
            end
        endcase
    end

endmodule

// ----- rtl/flp_out_buf.sv -----
// Result register with a skid stage, so a new byte is taken while a result waits.
// Depends on flp_pkg.
`timescale 1ns / 1ps

module flp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  flp_pkg::result_t push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output flp_pkg::result_t out_data
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    flp_pkg::result_t out_reg, out_next;
    flp_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    // Fill and drain of the two entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else
            out_valid_next = out_valid_reg && !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/lead_header_length_frame_parser.sv -----
// Lead/header/length frame parser. Takes one received byte per beat on rx and returns one
// event per byte on evt: a frame is four lead bytes, a header byte, a control byte, a length
// byte, that many payload bytes (streamed with their index) and an end byte that closes the
// frame as complete or aborted. A wrong lead or header byte restarts the hunt. Throughput is
// one byte per clock; each result is held in a result register backed by a one-entry skid
// stage, so rx stalls only when both hold unread results.
// Lead, header and end byte values are written on cfg (index 0, 1, 2; index 3 is ignored).
// Depends on flp_pkg, flp_if, flp_deframer and flp_out_buf.
`timescale 1ns / 1ps

module lead_header_length_frame_parser (
    input  logic  clk,
    input  logic  rst_n,
    flp_byte_if.sink   rx,
    flp_event_if.source evt,
    flp_cfg_if.sink    cfg
);

    logic             beat;
    logic             push_ready;
    flp_pkg::result_t result;
    flp_pkg::result_t out_data;
    flp_pkg::cfg_wr_t cfg_wr;

    // Register writes are always taken
    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign rx.ready = push_ready;
    assign beat     = rx.valid && push_ready;

    flp_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .rx_byte (rx.rx_byte),
        .cfg_wr  (cfg_wr),
        .result  (result)
    );

    flp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (beat),
        .push_data  (result),
        .push_ready (push_ready),
        .out_valid  (evt.valid),
        .out_ready  (evt.ready),
        .out_data   (out_data)
    );

    assign evt.event_res     = out_data.event_res;
    assign evt.byte_value    = out_data.byte_value;
    assign evt.payload_index = out_data.payload_index;
    assign evt.frame_control = out_data.frame_control;
    assign evt.frame_length  = out_data.frame_length;

endmodule

// ----- tb/lead_header_length_frame_parser_test.sv -----
// Self-checking testbench for lead_header_length_frame_parser: directed and random byte streams,
// register writes, random and long output stalls, all checked against an in-bench deframer.
// Depends on flp_pkg, flp_if and the parser RTL.
`timescale 1ns / 1ps

module lead_header_length_frame_parser_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [flp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {FLAW_NONE, FLAW_LEAD, FLAW_HEADER, FLAW_END} flaw_t;

    logic clk;
    logic rst_n;

    flp_byte_if  rx_ch ();
    flp_event_if evt_ch ();
    flp_cfg_if   cfg_ch ();

    lead_header_length_frame_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .evt   (evt_ch),
        .cfg   (cfg_ch)
    );

    // Deframer state and register copies used for prediction
    flp_pkg::phase_t hunt_phase;
    logic [2:0]      leads_matched;
    logic [7:0]      bytes_left;
    logic [7:0]      next_pos;
    logic [7:0]      ctrl_hold;
    logic [7:0]      len_hold;
    logic [7:0]      lead_reg;
    logic [7:0]      header_reg;
    logic [7:0]      end_reg;

    // Register values the stimulus builds frames from
    logic [7:0] gen_lead = flp_pkg::LEAD_BYTE_RST;
    logic [7:0] gen_header = flp_pkg::HEADER_BYTE_RST;
    logic [7:0] gen_end = flp_pkg::END_BYTE_RST;

    flp_pkg::result_t expected_events [$];
    int      error_count = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    bit      idle_on = 1'b1;
    int      hold_request = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    function automatic void clear_hunt();
        hunt_phase    = flp_pkg::PH_LEAD;
        leads_matched = '0;
        bytes_left    = '0;
        next_pos      = '0;
        ctrl_hold     = '0;
        len_hold      = '0;
    endfunction

    // Advance the deframer by one received byte and return the event it causes
    function automatic flp_pkg::result_t predict_event(input logic [7:0] b);
        flp_pkg::result_t r;
        r            = '0;
        r.event_res  = flp_pkg::EV_NONE;
        r.byte_value = b;
        case (hunt_phase)
            flp_pkg::PH_LEAD:
            begin
                if (b != lead_reg)
                    clear_hunt();
                else
                begin
                    leads_matched = leads_matched + 3'd1;
                    if (leads_matched >= flp_pkg::LEAD_COUNT)
                        hunt_phase = flp_pkg::PH_HEADER;
                end
            end
            flp_pkg::PH_HEADER:
            begin
                if (b != header_reg)
                    clear_hunt();
                else
                    hunt_phase = flp_pkg::PH_CTRL;
            end
            flp_pkg::PH_CTRL:
            begin
                ctrl_hold   = b;
                r.event_res = flp_pkg::EV_CONTROL;
                hunt_phase  = flp_pkg::PH_LEN;
            end
            flp_pkg::PH_LEN:
            begin
                len_hold    = b;
                bytes_left  = b;
                next_pos    = '0;
                r.event_res = flp_pkg::EV_LENGTH;
                hunt_phase  = (b == 8'h00) ? flp_pkg::PH_END : flp_pkg::PH_DATA;
            end
            flp_pkg::PH_DATA:
            begin
                r.event_res     = flp_pkg::EV_PAYLOAD;
                r.payload_index = next_pos;
                next_pos        = next_pos + 8'd1;
                bytes_left      = bytes_left - 8'd1;
                if (bytes_left == 8'h00)
                    hunt_phase = flp_pkg::PH_END;
            end
            flp_pkg::PH_END:
            begin
                if (b == end_reg)
                    r.event_res = flp_pkg::EV_COMPLETE;
                else
                    r.event_res = flp_pkg::EV_ABORTED;
                r.frame_control = ctrl_hold;
                r.frame_length  = len_hold;
                clear_hunt();
            end
            default:
                clear_hunt();
        endcase
        return r;
    endfunction

    // Track register writes and input beats, check every result beat
    always @(posedge clk)
    begin : event_checker
        flp_pkg::result_t want;
        if (!rst_n)
        begin
            lead_reg   = flp_pkg::LEAD_BYTE_RST;
            header_reg = flp_pkg::HEADER_BYTE_RST;
            end_reg    = flp_pkg::END_BYTE_RST;
            clear_hunt();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    flp_pkg::CFG_LEAD:   lead_reg = cfg_ch.data;
                    flp_pkg::CFG_HEADER: header_reg = cfg_ch.data;
                    flp_pkg::CFG_END:    end_reg = cfg_ch.data;
                    default:             ;
                endcase
            end
            if (rx_ch.valid && rx_ch.ready)
                expected_events.push_back(predict_event(rx_ch.rx_byte));
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("unexpected result beat", {5'd0, evt_ch.event_res}, 8'h00);
                else
                begin
                    want = expected_events.pop_front();
                    if (evt_ch.event_res !== want.event_res)
                        report_mismatch("event_res", {5'd0, evt_ch.event_res},
                                        {5'd0, want.event_res});
                    if (evt_ch.byte_value !== want.byte_value)
                        report_mismatch("byte_value", evt_ch.byte_value, want.byte_value);
                    if (evt_ch.payload_index !== want.payload_index)
                        report_mismatch("payload_index", evt_ch.payload_index,
                                        want.payload_index);
                    if (evt_ch.frame_control !== want.frame_control)
                        report_mismatch("frame_control", evt_ch.frame_control,
                                        want.frame_control);
                    if (evt_ch.frame_length !== want.frame_length)
                        report_mismatch("frame_length", evt_ch.frame_length, want.frame_length);
                end
            end
        end
    end

    // Result sink: random stall bursts, or a long hold when one is requested
    initial
    begin : event_sink
        int n;
        evt_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                evt_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                evt_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                evt_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                evt_ch.ready <= 1'b1;
            end
            else
                evt_ch.ready <= 1'b1;
        end
    end

    // Offer one byte, with an optional idle burst first; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Stop offering bytes until every expected result has arrived
    task automatic drain_events();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_events.size() != 0);
    endtask

    task automatic write_reg(input logic [flp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
        drain_events();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            flp_pkg::CFG_LEAD:   gen_lead = value;
            flp_pkg::CFG_HEADER: gen_header = value;
            flp_pkg::CFG_END:    gen_end = value;
            default:             ;
        endcase
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // New register setting; header sometimes equals the lead byte
    task automatic random_config();
        write_reg(flp_pkg::CFG_LEAD, pick_value());
        if ($urandom_range(0, 4) == 0)
            write_reg(flp_pkg::CFG_HEADER, gen_lead);
        else
            write_reg(flp_pkg::CFG_HEADER, pick_value());
        write_reg(flp_pkg::CFG_END, pick_value());
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    // One frame built from the current registers, optionally broken at one spot
    task automatic send_frame(input int len, input flaw_t flaw);
        int cut;
        cut = $urandom_range(0, flp_pkg::LEAD_COUNT - 1);
        for (int i = 0; i < flp_pkg::LEAD_COUNT; i++)
        begin
            if (flaw == FLAW_LEAD && i == cut)
            begin
                send_byte(gen_lead ^ 8'($urandom_range(1, 255)));
                return;
            end
            send_byte(gen_lead);
        end
        if (flaw == FLAW_HEADER)
        begin
            send_byte(gen_header ^ 8'($urandom_range(1, 255)));
            return;
        end
        send_byte(gen_header);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'(len));
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
        if (flaw == FLAW_END)
            send_byte(gen_end ^ 8'($urandom_range(1, 255)));
        else
            send_byte(gen_end);
    endtask

    // Reset values: one complete frame with extreme payload bytes
    task automatic test_default_frame();
        for (int i = 0; i < flp_pkg::LEAD_COUNT; i++)
            send_byte(flp_pkg::LEAD_BYTE_RST);
        send_byte(flp_pkg::HEADER_BYTE_RST);
        send_byte(8'hC3);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(flp_pkg::END_BYTE_RST);
    endtask

    // Bad lead, bad header that looks like a lead, then a zero-length frame that aborts
    task automatic test_hunt_restart();
        send_byte(flp_pkg::LEAD_BYTE_RST);
        send_byte(flp_pkg::LEAD_BYTE_RST);
        send_byte(8'h12);
        for (int i = 0; i <= flp_pkg::LEAD_COUNT; i++)
            send_byte(flp_pkg::LEAD_BYTE_RST);
        for (int i = 0; i < flp_pkg::LEAD_COUNT; i++)
            send_byte(flp_pkg::LEAD_BYTE_RST);
        send_byte(flp_pkg::HEADER_BYTE_RST);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    // Extreme settings, unused index, header equal to lead, write in the middle of a frame
    task automatic test_register_settings();
        write_reg(flp_pkg::CFG_LEAD, 8'h00);
        write_reg(flp_pkg::CFG_HEADER, 8'hFF);
        write_reg(flp_pkg::CFG_END, 8'hFF);
        write_reg(CFG_UNUSED, 8'h5A);
        send_frame(1, FLAW_NONE);
        write_reg(flp_pkg::CFG_LEAD, 8'hFF);
        write_reg(flp_pkg::CFG_HEADER, 8'hFF);
        write_reg(flp_pkg::CFG_END, 8'h00);
        send_frame(0, FLAW_NONE);
        for (int i = 0; i < flp_pkg::LEAD_COUNT; i++)
            send_byte(gen_lead);
        send_byte(gen_header);
        send_byte(8'h81);
        send_byte(8'h01);
        send_byte(8'h66);
        write_reg(flp_pkg::CFG_END, 8'h3C);
        send_byte(8'h3C);
    endtask

    // Long receiver hold while a maximum-length frame streams in, then a full pause
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        drain_events();
        hold_request = 60;
        send_frame(255, FLAW_NONE);
        drain_events();
        idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content, some broken frames and noise
    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int stop_at;
        int pick;
        int len;
        idle_on = with_idle;
        stop_at = bytes_sent + n_items;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 19) == 0)
                random_config();
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 79) == 0) ? 255 : $urandom_range(0, 12);
            if (pick == 0)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else if (pick == 1)
                send_frame(len, flaw_t'($urandom_range(FLAW_LEAD, FLAW_END)));
            else
                send_frame(len, FLAW_NONE);
        end
    endtask

    // Test sequence
    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= flp_pkg::CFG_LEAD;
        cfg_ch.data   <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frame();
        test_hunt_restart();
        test_register_settings();
        test_random_traffic(200, 1'b1);
        test_output_backpressure();
        test_random_traffic(250, 1'b1);
        test_random_traffic(150, 1'b0);

        drain_events();
        repeat (5) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch("results left over", 8'(expected_events.size()), 8'h00);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
